// File: rtl/buddy_page_allocator_assert.svh
// assertion macros for the buddy page allocator checker
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define BPA_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/bpa_pkg.sv
package bpa_pkg;

    localparam int NUM_ORDERS_DEF       = 11;
    localparam int POOL_PAGES_DEF       = 4096;
    localparam int FIRST_FREE_ORDER_DEF = 4;

    localparam int ORDER_W  = 4;
    localparam int BLK_W    = 12;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ORDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MEM    = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;

    typedef logic [3:0] bpa_op_t;

    localparam bpa_op_t OP_NONE      = 4'd0;
    localparam bpa_op_t OP_CLEAR     = 4'd1;
    localparam bpa_op_t OP_CAPTURE   = 4'd2;
    localparam bpa_op_t OP_INC_P     = 4'd3;
    localparam bpa_op_t OP_NO_MEM    = 4'd4;
    localparam bpa_op_t OP_HEAD_RD   = 4'd5;
    localparam bpa_op_t OP_SPLIT_B   = 4'd6;
    localparam bpa_op_t OP_SPLIT_A   = 4'd7;
    localparam bpa_op_t OP_POP       = 4'd8;
    localparam bpa_op_t OP_WALK_INIT = 4'd9;
    localparam bpa_op_t OP_ADV_RD    = 4'd10;
    localparam bpa_op_t OP_ADV       = 4'd11;
    localparam bpa_op_t OP_CUR_RD    = 4'd12;
    localparam bpa_op_t OP_UNLINK    = 4'd13;
    localparam bpa_op_t OP_PUSH      = 4'd14;
    localparam bpa_op_t OP_EMIT      = 4'd15;

    typedef struct packed {
        bpa_op_t op;
    } bpa_cmd_t;

    typedef struct packed {
        logic is_free;
        logic bad_order;
        logic fits;
        logic p_at_end;
        logic head_none;
        logic p_gt_order;
        logic at_top;
        logic cur_none;
        logic found;
        logic steps_max;
        logic clr_last;
        logic out_free;
    } bpa_stat_t;

endpackage

// File: rtl/bpa_ctrl.sv
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  bpa_stat_t stat,
    output bpa_cmd_t  cmd
);

    localparam logic [4:0] S_CLEAR     = 5'd0;
    localparam logic [4:0] S_IDLE      = 5'd1;
    localparam logic [4:0] S_CHECK     = 5'd2;
    localparam logic [4:0] S_SCAN      = 5'd3;
    localparam logic [4:0] S_SPLIT_RD  = 5'd4;
    localparam logic [4:0] S_SPLIT_B   = 5'd5;
    localparam logic [4:0] S_SPLIT_A   = 5'd6;
    localparam logic [4:0] S_POP_RD    = 5'd7;
    localparam logic [4:0] S_POP       = 5'd8;
    localparam logic [4:0] S_WALK_INIT = 5'd9;
    localparam logic [4:0] S_WALK_CHK  = 5'd10;
    localparam logic [4:0] S_ADV_RD    = 5'd11;
    localparam logic [4:0] S_ADV       = 5'd12;
    localparam logic [4:0] S_UNLINK_RD = 5'd13;
    localparam logic [4:0] S_UNLINK    = 5'd14;
    localparam logic [4:0] S_PUSH      = 5'd15;
    localparam logic [4:0] S_DONE      = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.bad_order)
                    state_next = S_DONE;
                else if (!stat.is_free)
                    state_next = S_SCAN;
                else if (stat.fits)
                    state_next = S_WALK_INIT;
                else
                    state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (stat.p_at_end)
                begin
                    cmd.op     = OP_NO_MEM;
                    state_next = S_DONE;
                end
                else if (stat.head_none)
                    cmd.op = OP_INC_P;
                else if (stat.p_gt_order)
                    state_next = S_SPLIT_RD;
                else
                    state_next = S_POP_RD;
            end
            S_SPLIT_RD:
            begin
                cmd.op     = OP_HEAD_RD;
                state_next = S_SPLIT_B;
            end
            S_SPLIT_B:
            begin
                cmd.op     = OP_SPLIT_B;
                state_next = S_SPLIT_A;
            end
            S_SPLIT_A:
            begin
                cmd.op     = OP_SPLIT_A;
                state_next = S_SCAN;
            end
            S_POP_RD:
            begin
                cmd.op     = OP_HEAD_RD;
                state_next = S_POP;
            end
            S_POP:
            begin
                cmd.op     = OP_POP;
                state_next = S_DONE;
            end
            S_WALK_INIT:
            begin
                cmd.op     = OP_WALK_INIT;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                // buddy match wins even when the step limit is reached
                if (stat.at_top)
                    state_next = S_PUSH;
                else if (stat.found)
                    state_next = S_UNLINK_RD;
                else if (stat.cur_none || stat.steps_max)
                    state_next = S_PUSH;
                else
                    state_next = S_ADV_RD;
            end
            S_ADV_RD:
            begin
                cmd.op     = OP_ADV_RD;
                state_next = S_ADV;
            end
            S_ADV:
            begin
                cmd.op     = OP_ADV;
                state_next = S_WALK_CHK;
            end
            S_UNLINK_RD:
            begin
                cmd.op     = OP_CUR_RD;
                state_next = S_UNLINK;
            end
            S_UNLINK:
            begin
                cmd.op     = OP_UNLINK;
                state_next = S_WALK_INIT;
            end
            S_PUSH:
            begin
                cmd.op     = OP_PUSH;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/bpa_dpath.sv
module bpa_dpath
    import bpa_pkg::*;
#(
    parameter int NUM_ORDERS       = NUM_ORDERS_DEF,
    parameter int POOL_PAGES       = POOL_PAGES_DEF,
    parameter int FIRST_FREE_ORDER = FIRST_FREE_ORDER_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [0:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    input  bpa_cmd_t            cmd,
    output bpa_stat_t           stat
);

    localparam int AW   = $clog2(POOL_PAGES);
    localparam int LW   = AW + 1;
    localparam int MX1  = (AW > NUM_ORDERS) ? AW : NUM_ORDERS;
    localparam int CW   = ((MX1 > BLK_W) ? MX1 : BLK_W) + 2;
    localparam int OW   = $clog2(NUM_ORDERS + 1);
    localparam int OIW  = $clog2(NUM_ORDERS);
    localparam int TOP  = NUM_ORDERS - 1;
    localparam logic [LW-1:0] NONE = LW'(POOL_PAGES);
    localparam logic [CW-1:0] POOL_C = CW'(POOL_PAGES);
    localparam logic [CW-1:0] AREA_C = CW'(1) << TOP;

    function automatic logic [LW-1:0] head_init(input int o);
        logic [LW-1:0] v;
        v = NONE;
        if (o == TOP)
        begin
            if ((longint'(2) << TOP) <= longint'(POOL_PAGES))
                v = LW'(longint'(1) << TOP);
        end
        else if (o >= FIRST_FREE_ORDER && (longint'(2) << o) <= longint'(POOL_PAGES))
            v = LW'(longint'(1) << o);
        return v;
    endfunction

    // top list is chained in ascending order at reset
    function automatic logic [LW-1:0] link_init(input logic [CW-1:0] k);
        logic [LW-1:0] v;
        v = NONE;
        if ((k & (AREA_C - CW'(1))) == '0 && k >= AREA_C && k + AREA_C + AREA_C <= POOL_C)
            v = LW'(k + AREA_C);
        return v;
    endfunction

    logic [LW-1:0]       head_reg [NUM_ORDERS];
    logic [LW-1:0]       mem [POOL_PAGES];
    logic [LW-1:0]       rdata_reg;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       waddr;
    logic [LW-1:0]       wdata;
    logic                we;

    logic                req_reg;
    logic [ORDER_W-1:0]  order_reg;
    logic [OW-1:0]       p_reg;
    logic [CW-1:0]       idx_reg;
    logic [LW-1:0]       a_reg;
    logic [LW-1:0]       cur_reg;
    logic [LW-1:0]       prev_reg;
    logic [LW-1:0]       steps_reg;
    logic [AW:0]         clr_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [BLK_W-1:0]    res_idx_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic [OIW-1:0]      hp;
    logic [OIW-1:0]      hp_m1;
    logic [LW-1:0]       head_p;
    logic [LW-1:0]       head_p_m1;
    logic [CW-1:0]       size;
    logic [CW-1:0]       half;
    logic [CW-1:0]       b_val;
    logic                b_ok;
    logic [CW-1:0]       buddy;
    logic [CW-1:0]       in_blk;
    logic [ORDER_W-1:0]  in_order;

    assign hp        = p_reg[OIW-1:0];
    assign hp_m1     = hp - OIW'(1);
    assign head_p    = head_reg[hp];
    assign head_p_m1 = head_reg[hp_m1];
    assign size      = CW'(1) << p_reg;
    assign half      = CW'(1) << (p_reg - OW'(1));
    assign b_val     = CW'(a_reg) + half;
    assign b_ok      = b_val < POOL_C;
    assign buddy     = idx_reg ^ size;
    assign in_order  = s_tdata[ORDER_W-1:0];
    assign in_blk    = CW'(s_tdata[ORDER_W +: BLK_W]);

    assign stat.is_free    = (req_reg != REQ_ALLOC);
    assign stat.bad_order  = ((OW + 1)'(order_reg) >= (OW + 1)'(NUM_ORDERS));
    assign stat.fits       = idx_reg + (CW'(1) << order_reg) <= POOL_C;
    assign stat.p_at_end   = (p_reg == OW'(NUM_ORDERS));
    assign stat.head_none  = (head_p >= NONE);
    assign stat.p_gt_order = ((OW + 1)'(p_reg) > (OW + 1)'(order_reg));
    assign stat.at_top     = (p_reg == OW'(TOP));
    assign stat.cur_none   = (cur_reg >= NONE);
    assign stat.found      = (CW'(cur_reg) == buddy);
    assign stat.steps_max  = (steps_reg == LW'(POOL_PAGES));
    assign stat.clr_last   = (clr_reg == (AW + 1)'(POOL_PAGES - 1));
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = head_p;
        raddr = cur_reg[AW-1:0];
        case (cmd.op)
            OP_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg[AW-1:0];
                wdata = link_init(CW'(clr_reg));
            end
            OP_HEAD_RD:
            begin
                raddr = head_p[AW-1:0];
            end
            OP_SPLIT_B:
            begin
                we    = b_ok;
                waddr = b_val[AW-1:0];
                wdata = head_p_m1;
            end
            OP_SPLIT_A:
            begin
                we    = 1'b1;
                waddr = a_reg[AW-1:0];
                wdata = head_p;
            end
            OP_UNLINK:
            begin
                we    = (prev_reg < NONE);
                waddr = prev_reg[AW-1:0];
                wdata = rdata_reg;
            end
            OP_PUSH:
            begin
                we = 1'b1;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ORDERS; i++)
                head_reg[i] <= head_init(i);
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_EMIT)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            case (cmd.op)
                OP_CLEAR:
                begin
                    clr_reg <= clr_reg + (AW + 1)'(1);
                end
                OP_SPLIT_B:
                begin
                    head_reg[hp] <= rdata_reg;
                    if (b_ok)
                        head_reg[hp_m1] <= LW'(b_val);
                end
                OP_SPLIT_A:
                begin
                    head_reg[hp] <= a_reg;
                end
                OP_POP:
                begin
                    head_reg[hp] <= (a_reg >= NONE) ? NONE : rdata_reg;
                end
                OP_UNLINK:
                begin
                    if (prev_reg >= NONE)
                        head_reg[hp] <= rdata_reg;
                end
                OP_PUSH:
                begin
                    head_reg[hp] <= LW'(idx_reg);
                end
                default:
                begin
                    clr_reg <= clr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                req_reg     <= s_tuser[0];
                order_reg   <= in_order;
                p_reg       <= OW'(in_order);
                idx_reg     <= in_blk;
                res_idx_reg <= '0;
                status_reg  <= ((OW + 1)'(in_order) >= (OW + 1)'(NUM_ORDERS))
                               ? ST_BAD_ORDER : ST_OK;
            end
            OP_INC_P:
            begin
                p_reg <= p_reg + OW'(1);
            end
            OP_NO_MEM:
            begin
                status_reg <= ST_NO_MEM;
            end
            OP_HEAD_RD:
            begin
                a_reg <= head_p;
            end
            OP_SPLIT_B:
            begin
                p_reg <= p_reg - OW'(1);
            end
            OP_POP:
            begin
                res_idx_reg <= (a_reg >= NONE) ? '0 : BLK_W'(a_reg);
            end
            OP_WALK_INIT:
            begin
                cur_reg   <= head_p;
                prev_reg  <= NONE;
                steps_reg <= '0;
            end
            OP_ADV_RD:
            begin
                prev_reg <= cur_reg;
            end
            OP_ADV:
            begin
                cur_reg   <= rdata_reg;
                steps_reg <= steps_reg + LW'(1);
            end
            OP_UNLINK:
            begin
                idx_reg <= idx_reg & ~size;
                p_reg   <= p_reg + OW'(1);
            end
            OP_EMIT:
            begin
                m_tdata_reg <= {{(M_DATA_W - ORDER_W - BLK_W - STATUS_W){1'b0}},
                                order_reg, res_idx_reg, status_reg};
            end
            default:
            begin
                a_reg <= a_reg;
            end
        endcase
    end

endmodule

// File: rtl/buddy_page_allocator.sv
// channel  | dir | beat fields (tdata from bit 0 up)
// s_*      | in  | tdata: order[3:0], block_index[15:4]; tuser: req_type
// m_*      | out | tdata: status[1:0], result_index[13:2], result_order[17:14], zero pad
//
// one request at a time; a bad order or a block past the pool end goes from the check
// straight to the output register, and a top-order free is pushed without a list walk
// alloc: scan orders upward; per split read the head, write both halves and rescan; then pop
// free: per order visited walk the list node by node, unlink the buddy on a match and merge,
// then push; every walk goes through the link memory's single read port
// after reset a clearing pass loads the link memory before s_tready;
// a finished result waits in the output register while m_tready is low
module buddy_page_allocator
    import bpa_pkg::*;
#(
    parameter int NUM_ORDERS       = NUM_ORDERS_DEF,
    parameter int POOL_PAGES       = POOL_PAGES_DEF,
    parameter int FIRST_FREE_ORDER = FIRST_FREE_ORDER_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // order, block_index
    input  logic [0:0]          s_tuser,   // req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status, result_index, result_order
);

    bpa_cmd_t  cmd;
    bpa_stat_t stat;

    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpa_dpath #(
        .NUM_ORDERS       (NUM_ORDERS),
        .POOL_PAGES       (POOL_PAGES),
        .FIRST_FREE_ORDER (FIRST_FREE_ORDER)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// File: rtl/bpa_checker.sv
`include "buddy_page_allocator_assert.svh"

module bpa_checker
    import bpa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    `BPA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped while stalled")
    `BPA_NEVER(a_status_code, m_tvalid && m_tdata[1:0] == 2'd3, "undefined status code")
    `BPA_ASSERT(a_idx_zero, m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[13:2] == '0, "index set on error")
    `BPA_ASSERT(a_one_at_time, s_tvalid && s_tready |=> !s_tready, "second request taken while busy")

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb.sv
module tb;
    import bpa_pkg::*;

    localparam int TOP_ORDER = NUM_ORDERS_DEF - 1;
    localparam int NULL_LINK = POOL_PAGES_DEF;
    localparam logic REQ_FREE = 1'b1;
    localparam int N_RANDOM = 400;
    // corrupt lists can make each merge level walk the whole pool
    localparam longint CYCLE_LIMIT = 250000000;

    typedef struct packed {
        logic                is_free;
        logic [ORDER_W-1:0]  order;
        logic [BLK_W-1:0]    blk;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    index;
        logic [ORDER_W-1:0]  order;
    } reply_t;

    typedef struct {
        request_t req;
        logic     typed;   // expected reply given in the table
        reply_t   rep;
    } vector_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [0:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    buddy_page_allocator DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // allocator shadow
    int free_head [NUM_ORDERS_DEF];
    int page_link [POOL_PAGES_DEF];
    reply_t pending_replies[$];
    request_t stimulus[$];
    int held_blocks[$];   // index*16 + order of blocks handed out
    int errors = 0;
    bit sender_done = 0;
    longint cycles = 0;
    bit long_stall = 0;

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) cycles <= cycles + 1;

    function automatic void push_free(int o, int idx);
        if (o >= NUM_ORDERS_DEF || idx >= NULL_LINK) return;
        page_link[idx] = free_head[o];
        free_head[o] = idx;
    endfunction

    function automatic int pop_free(int o);
        int idx;
        idx = free_head[o];
        free_head[o] = (idx >= NULL_LINK) ? NULL_LINK : page_link[idx];
        return idx;
    endfunction

    function automatic void shadow_reset();
        for (int o = 0; o < NUM_ORDERS_DEF; o++) free_head[o] = NULL_LINK;
        for (int k = 0; k < POOL_PAGES_DEF; k++) page_link[k] = NULL_LINK;
        for (int k = POOL_PAGES_DEF / (1 << TOP_ORDER); k >= 2; k--)
            push_free(TOP_ORDER, (k - 1) * (1 << TOP_ORDER));
        for (int o = FIRST_FREE_ORDER_DEF; o < TOP_ORDER; o++)
            if ((2 << o) <= POOL_PAGES_DEF) push_free(o, 1 << o);
    endfunction

    function automatic reply_t predict_reply(request_t r);
        reply_t y;
        int p, a, o, idx, size, buddy, prev, cur, steps;
        y = '0;
        y.order = r.order;
        if (r.order >= NUM_ORDERS_DEF) begin
            y.status = ST_BAD_ORDER;
        end
        else if (!r.is_free) begin
            p = r.order;
            while (p < NUM_ORDERS_DEF && free_head[p] >= NULL_LINK) p++;
            if (p >= NUM_ORDERS_DEF) begin
                y.status = ST_NO_MEM;
            end
            else begin
                while (p > r.order) begin
                    a = pop_free(p);
                    push_free(p - 1, a + (1 << (p - 1)));
                    push_free(p - 1, a);
                    p--;
                end
                idx = pop_free(r.order);
                if (idx >= NULL_LINK) idx = 0;
                y.status = ST_OK;
                y.index = idx[BLK_W-1:0];
            end
        end
        else begin
            o = r.order;
            idx = r.blk;
            y.status = ST_OK;
            if (idx + (1 << o) <= POOL_PAGES_DEF) begin
                while (o < TOP_ORDER) begin
                    size = 1 << o;
                    buddy = idx ^ size;
                    prev = NULL_LINK;
                    cur = free_head[o];
                    steps = 0;
                    while (cur < NULL_LINK && steps < POOL_PAGES_DEF) begin
                        if (cur == buddy) break;
                        prev = cur;
                        cur = page_link[cur];
                        steps++;
                    end
                    if (cur >= NULL_LINK || cur != buddy) break;
                    if (prev >= NULL_LINK) free_head[o] = page_link[cur];
                    else page_link[prev] = page_link[cur];
                    idx = idx & ~size;
                    o++;
                end
                push_free(o, idx);
            end
        end
        return y;
    endfunction

    function automatic request_t mk(logic f, int o, int b);
        request_t r;
        r.is_free = f;
        r.order = o[ORDER_W-1:0];
        r.blk = b[BLK_W-1:0];
        return r;
    endfunction

    function automatic reply_t rp(logic [STATUS_W-1:0] s, int i, int o);
        reply_t y;
        y.status = s;
        y.index = i[BLK_W-1:0];
        y.order = o[ORDER_W-1:0];
        return y;
    endfunction

    // request stream generator: mostly alloc/free of real blocks, some noise
    function automatic request_t random_request();
        int pick, hb, k;
        pick = $urandom_range(0, 99);
        if (pick < 45) return mk(REQ_ALLOC, ($urandom_range(0, 3) == 0) ?
                                 $urandom_range(0, TOP_ORDER) : $urandom_range(0, 4), 0);
        if (pick < 85 && held_blocks.size() > 0) begin
            k = $urandom_range(0, held_blocks.size() - 1);
            hb = held_blocks[k];
            held_blocks.delete(k);
            return mk(REQ_FREE, hb % 16, hb / 16);
        end
        if (pick < 92) return mk(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                                 $urandom_range(0, 4095));
        return mk(REQ_FREE, $urandom_range(0, TOP_ORDER), $urandom_range(0, 4095));
    endfunction

    task automatic send_request(request_t r);
        int gap;
        gap = $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.is_free;
        s_tdata <= {r.blk, r.order};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // sender: table then random stream; prediction made at acceptance order
    initial begin
        vector_t table_rows[$];
        reply_t y;
        request_t r;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        rst_n = 0;
        shadow_reset();
        table_rows = '{
            '{mk(REQ_ALLOC, 15, 0), 1, rp(ST_BAD_ORDER, 0, 15)},
            '{mk(REQ_FREE, 11, 4095), 1, rp(ST_BAD_ORDER, 0, 11)},
            '{mk(REQ_ALLOC, 4, 0), 1, rp(ST_OK, 16, 4)},
            '{mk(REQ_ALLOC, 0, 0), 1, rp(ST_OK, 32, 0)},
            '{mk(REQ_ALLOC, TOP_ORDER, 0), 1, rp(ST_OK, 1024, TOP_ORDER)},
            '{mk(REQ_FREE, TOP_ORDER, 1024), 0, '0},
            '{mk(REQ_FREE, 0, 4095), 1, rp(ST_OK, 0, 0)},
            '{mk(REQ_FREE, 1, 4095), 1, rp(ST_OK, 0, 1)},
            '{mk(REQ_FREE, 0, 32), 0, '0},
            '{mk(REQ_FREE, 4, 16), 0, '0},
            '{mk(REQ_FREE, 4, 16), 0, '0},
            '{mk(REQ_ALLOC, 9, 0), 0, '0},
            '{mk(REQ_ALLOC, TOP_ORDER, 0), 0, '0},
            '{mk(REQ_ALLOC, TOP_ORDER, 0), 0, '0},
            '{mk(REQ_ALLOC, TOP_ORDER, 0), 0, '0},
            '{mk(REQ_ALLOC, TOP_ORDER, 0), 1, rp(ST_NO_MEM, 0, TOP_ORDER)},
            '{mk(REQ_FREE, 3, 4095), 0, '0},
            '{mk(REQ_FREE, TOP_ORDER, 3072), 0, '0},
            '{mk(REQ_FREE, 0, 0), 0, '0}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        foreach (table_rows[i]) begin
            // the shadow always steps so later rows stay in sync
            y = predict_reply(table_rows[i].req);
            if (table_rows[i].typed)
                pending_replies.push_back(table_rows[i].rep);
            else
                pending_replies.push_back(y);
            send_request(table_rows[i].req);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 100) long_stall = 1;
            r = random_request();
            y = predict_reply(r);
            if (r.is_free == REQ_ALLOC && y.status == ST_OK && r.order <= TOP_ORDER)
                held_blocks.push_back(y.index * 16 + r.order);
            pending_replies.push_back(y);
            send_request(r);
        end
        s_tvalid <= 1'b0;
        sender_done = 1;
    end

    // receiver with random backpressure and one long hold-off
    initial begin
        int gap;
        m_tready = 0;
        @(posedge rst_n);
        forever begin
            if (long_stall) begin
                long_stall = 0;
                m_tready <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            gap = $urandom_range(0, 11);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // reply checker
    always @(posedge clk) begin
        reply_t got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.index = m_tdata[13:2];
            got.order = m_tdata[17:14];
            if (pending_replies.size() == 0) begin
                $error("reply with nothing expected: %h", m_tdata);
                errors++;
            end
            else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.index !== want.index) begin
                    $error("result_index: expected %0d, got %0d", want.index, got.index);
                    errors++;
                end
                if (got.order !== want.order) begin
                    $error("result_order: expected %0d, got %0d", want.order, got.order);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (sender_done && pending_replies.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
